/* design/assert_macros.svh */
// assertion macros for the pair force block
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ck, rn, pre, post) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ck, rn, pre, post)
`define ASSERT_NEXT(lbl, ck, rn, pre, post)
`endif
`endif

/* design/ljpf_pkg.sv */
// shared types, constants, stage numbers and saturation helpers
// no dependencies
package ljpf_pkg;

    localparam int LEN_W      = 24;
    localparam int DIR_W      = 16;
    localparam int WGT_W      = 16;
    localparam int RES_W      = 48;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam int Q_W = 49;
    localparam int I_W = 62;
    localparam int O_W = 47;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA   = 8'd0,
        REG_ATTRACT = 8'd1
    } ljpf_reg_t;

    localparam logic [LEN_W-1:0] ALPHA_RESET   = 24'd262144;
    localparam logic             ATTRACT_RESET = 1'b1;

    localparam logic [I_W-1:0] ICAP   = '1;
    localparam logic [I_W-1:0] GF_LIM = ICAP / 62'd6;
    localparam logic [O_W-1:0] OCAP   = '1;

    // stage numbers, stage 0 is the input register
    localparam int ST_QDONE = Q_W;
    localparam int ST_S2    = ST_QDONE + 3;
    localparam int ST_S4    = ST_S2 + 3;
    localparam int ST_T     = ST_S4 + 3;
    localparam int ST_D     = ST_T + 1;
    localparam int ST_G     = ST_D + 3;
    localparam int ST_GF6   = ST_G + 1;
    localparam int ST_KINIT = ST_GF6 + 1;
    localparam int ST_KDONE = ST_KINIT + I_W;
    localparam int ST_EMAG  = ST_G + 3;
    localparam int ST_FMAG  = ST_KDONE + 3;
    localparam int ST_DPROD = ST_FMAG + 1;
    localparam int ST_LAST  = ST_DPROD + 1;
    localparam int ST_EPS   = 1 + LEN_W;
    localparam int ST_AE    = ST_EPS + 1;
    localparam int ST_C     = ST_AE + 1;

    typedef struct packed {
        logic signed [RES_W-1:0] force_x;
        logic signed [RES_W-1:0] force_y;
        logic signed [RES_W-1:0] force_z;
        logic signed [RES_W-1:0] energy_term;
        logic                    too_close;
        logic                    overflow;
    } ljpf_res_t;

    // product >> 24, capped at ICAP, flag in the top bit
    function automatic logic [I_W:0] cap_q24(input logic [127:0] p);
        logic ovf;
        ovf = (p[127:86] != '0);
        return ovf ? {1'b1, ICAP} : {1'b0, p[85:24]};
    endfunction

    // product >> 54, capped at OCAP, flag in the top bit
    function automatic logic [O_W:0] cap_q54(input logic [127:0] p);
        logic ovf;
        ovf = (p[127:101] != '0);
        return ovf ? {1'b1, OCAP} : {1'b0, p[100:54]};
    endfunction

endpackage

/* design/ljpf_if.sv */
// channel interfaces: pair input, result output, configuration write
// depends on ljpf_pkg
interface ljpf_in_if;
    logic                              valid;
    logic                              ready;
    logic [ljpf_pkg::LEN_W-1:0]        distance;
    logic signed [ljpf_pkg::DIR_W-1:0] dir_x;
    logic signed [ljpf_pkg::DIR_W-1:0] dir_y;
    logic signed [ljpf_pkg::DIR_W-1:0] dir_z;
    logic [ljpf_pkg::LEN_W-1:0]        sigma_a;
    logic [ljpf_pkg::LEN_W-1:0]        eps_a;
    logic [ljpf_pkg::LEN_W-1:0]        sigma_b;
    logic [ljpf_pkg::LEN_W-1:0]        eps_b;
    logic [ljpf_pkg::WGT_W-1:0]        weight;
    modport source (output valid, distance, dir_x, dir_y, dir_z, sigma_a, eps_a,
                    sigma_b, eps_b, weight, input ready);
    modport sink (input valid, distance, dir_x, dir_y, dir_z, sigma_a, eps_a,
                  sigma_b, eps_b, weight, output ready);
endinterface

interface ljpf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ljpf_pkg::RES_W-1:0] force_x;
    logic signed [ljpf_pkg::RES_W-1:0] force_y;
    logic signed [ljpf_pkg::RES_W-1:0] force_z;
    logic signed [ljpf_pkg::RES_W-1:0] energy_term;
    logic                              too_close;
    logic                              overflow;
    modport source (output valid, force_x, force_y, force_z, energy_term, too_close,
                    overflow, input ready);
    modport sink (input valid, force_x, force_y, force_z, energy_term, too_close,
                  overflow, output ready);
endinterface

interface ljpf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ljpf_pkg::CFG_IDX_W-1:0]      idx;
    logic [ljpf_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, idx, data, input ready);
    modport sink (input valid, idx, data, output ready);
endinterface

/* design/ljpf_mul.sv */
// two-stage 64x64 unsigned multiplier built from four 32x32 partial products
// no dependencies
module ljpf_mul (
    input  logic         clk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] p
);

    logic [63:0]  pp00_reg;
    logic [63:0]  pp01_reg;
    logic [63:0]  pp10_reg;
    logic [63:0]  pp11_reg;
    logic [127:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= a[31:0] * b[31:0];
            pp01_reg <= a[31:0] * b[63:32];
            pp10_reg <= a[63:32] * b[31:0];
            pp11_reg <= a[63:32] * b[63:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= {64'd0, pp00_reg} + {32'd0, pp01_reg, 32'd0}
                   + {32'd0, pp10_reg, 32'd0} + {pp11_reg, 64'd0};
        end
    end

    assign p = p_reg;

endmodule

/* design/lj_pair_force.sv */
// Lennard-Jones 12-6 pair force pipeline: takes one pair per clock unless
// stalled by a full skid stage, and returns its force vector and energy term.
// The depth is set by the two bit-per-stage dividers (49 stages for sigma/r and
// 62 for the force over r) and the chained two-stage multipliers between them.
// A result waiting at the output does not block the input at once: a one-entry
// skid stage takes the next result, and only when both are full does ready drop.
// Configuration writes are taken in any cycle and always complete immediately.
// Depends on ljpf_pkg, ljpf_if, ljpf_mul and assert_macros.svh.
`include "assert_macros.svh"

module lj_pair_force (
    input  logic        clk,
    input  logic        rst_n,
    ljpf_cfg_if.sink    cfg,
    ljpf_in_if.sink     pair,
    ljpf_out_if.source  result
);

    localparam int L = ljpf_pkg::LEN_W;

    logic en;
    logic take;

    logic [L-1:0] alpha_reg;
    logic         attract_reg;

    logic [ljpf_pkg::ST_LAST:0]   vld_reg;
    logic [ljpf_pkg::ST_DPROD:0]  sat_reg;
    logic [ljpf_pkg::ST_DPROD:1]  sat_in;
    logic [ljpf_pkg::ST_DPROD:0]  zero_reg;
    logic [ljpf_pkg::ST_DPROD:0]  close_reg;

    logic [L-1:0]                    r_reg   [0:ljpf_pkg::ST_KDONE];
    logic [ljpf_pkg::DIR_W-1:0]      dir_reg [0:ljpf_pkg::ST_FMAG][0:2];
    logic [ljpf_pkg::WGT_W-1:0]      w_reg   [0:ljpf_pkg::ST_AE];
    logic [L-1:0]                    ea_reg;
    logic [L-1:0]                    eb_reg;
    logic [L:0]                      sig_sum;

    logic [L-1:0]               qa_rem_reg [0:ljpf_pkg::ST_QDONE];
    logic [ljpf_pkg::Q_W-1:0]   qa_dvd_reg [0:ljpf_pkg::ST_QDONE];
    logic [ljpf_pkg::Q_W-1:0]   qa_quo_reg [0:ljpf_pkg::ST_QDONE];
    logic [L:0]                 qa_try     [1:ljpf_pkg::ST_QDONE];
    logic [ljpf_pkg::ST_QDONE:1] qa_ge;

    logic [47:0]  sq_x_reg    [1:ljpf_pkg::ST_EPS];
    logic [25:0]  sq_rem_reg  [1:ljpf_pkg::ST_EPS];
    logic [L-1:0] sq_root_reg [1:ljpf_pkg::ST_EPS];
    logic [27:0]  sq_try      [2:ljpf_pkg::ST_EPS];
    logic [27:0]  sq_trial    [2:ljpf_pkg::ST_EPS];
    logic [ljpf_pkg::ST_EPS:2] sq_ge;

    logic [47:0] ae_reg;
    logic [63:0] c_reg [ljpf_pkg::ST_C:ljpf_pkg::ST_KDONE];

    logic [127:0] p_s2;
    logic [127:0] p_s4;
    logic [127:0] p_t;
    logic [127:0] p_g;
    logic [127:0] p_gf;
    logic [127:0] p_e;
    logic [127:0] p_f;

    logic [ljpf_pkg::I_W:0] s2_cap;
    logic [ljpf_pkg::I_W:0] s4_cap;
    logic [ljpf_pkg::I_W:0] t_cap;
    logic [ljpf_pkg::I_W:0] g_cap;
    logic [ljpf_pkg::I_W:0] gf_cap;
    logic [ljpf_pkg::O_W:0] e_cap;
    logic [ljpf_pkg::O_W:0] f_cap;

    logic [ljpf_pkg::I_W-1:0] s2_reg [ljpf_pkg::ST_S2:ljpf_pkg::ST_S4];
    logic [ljpf_pkg::I_W-1:0] s4_reg;
    logic [ljpf_pkg::I_W-1:0] t_reg  [ljpf_pkg::ST_T:ljpf_pkg::ST_D];
    logic [ljpf_pkg::I_W-1:0] d_reg;
    logic [ljpf_pkg::I_W:0]   h_reg;
    logic [ljpf_pkg::I_W-1:0] g_reg;
    logic [ljpf_pkg::I_W-1:0] gf_reg;
    logic [ljpf_pkg::I_W-1:0] gf6_reg;
    logic                     gf_lim_sat;
    logic                     k_ovf;
    logic [ljpf_pkg::ST_KDONE:ljpf_pkg::ST_KINIT] ksat_reg;
    logic [ljpf_pkg::ST_EMAG-1:ljpf_pkg::ST_D]    eneg_reg;
    logic [ljpf_pkg::ST_DPROD:ljpf_pkg::ST_D]     fneg_reg;

    logic [24:0]              attr_q;
    logic [ljpf_pkg::I_W-1:0] attr62;
    logic [ljpf_pkg::I_W:0]   attr63;
    logic [ljpf_pkg::I_W:0]   two_t;

    logic [L-1:0]               kb_rem_reg [ljpf_pkg::ST_KINIT:ljpf_pkg::ST_KDONE];
    logic [ljpf_pkg::I_W-1:0]   kb_dvd_reg [ljpf_pkg::ST_KINIT:ljpf_pkg::ST_KDONE];
    logic [ljpf_pkg::I_W-1:0]   kb_quo_reg [ljpf_pkg::ST_KINIT:ljpf_pkg::ST_KDONE];
    logic [L:0]                 kb_try     [ljpf_pkg::ST_KINIT+1:ljpf_pkg::ST_KDONE];
    logic [ljpf_pkg::ST_KDONE:ljpf_pkg::ST_KINIT+1] kb_ge;
    logic [ljpf_pkg::I_W-1:0]   k_val;

    logic signed [ljpf_pkg::RES_W-1:0] energy_reg [ljpf_pkg::ST_EMAG:ljpf_pkg::ST_DPROD];
    logic [ljpf_pkg::O_W-1:0]          fmag_reg;
    logic [62:0]                       dprod_reg [0:2];
    logic [2:0]                        dneg_reg;
    logic [ljpf_pkg::DIR_W-1:0]        dmag     [0:2];

    logic [48:0]              fm      [0:2];
    logic [2:0]               f_sat;
    logic [ljpf_pkg::O_W-1:0] f_mag   [0:2];
    logic [ljpf_pkg::RES_W-1:0] f_val [0:2];

    ljpf_pkg::ljpf_res_t res_next;
    ljpf_pkg::ljpf_res_t res_reg;
    ljpf_pkg::ljpf_res_t out_reg;
    ljpf_pkg::ljpf_res_t skid_reg;
    logic                out_vld_reg;
    logic                skid_vld_reg;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= ljpf_pkg::ALPHA_RESET;
            attract_reg <= ljpf_pkg::ATTRACT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.idx)
                ljpf_pkg::REG_ALPHA:   alpha_reg   <= cfg.data[L-1:0];
                ljpf_pkg::REG_ATTRACT: attract_reg <= cfg.data[0];
                default:               alpha_reg   <= alpha_reg;
            endcase
        end
    end

    assign en         = !skid_vld_reg;
    assign pair.ready = en;
    assign take       = out_vld_reg & result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ljpf_pkg::ST_LAST-1:0], pair.valid};
        end
    end

    assign sig_sum = {1'b0, pair.sigma_a} + {1'b0, pair.sigma_b};

    // input stage and delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]      <= pair.distance;
            zero_reg[0]   <= (pair.distance == '0);
            close_reg[0]  <= (sig_sum > {1'b0, pair.distance});
            dir_reg[0][0] <= pair.dir_x;
            dir_reg[0][1] <= pair.dir_y;
            dir_reg[0][2] <= pair.dir_z;
            w_reg[0]      <= pair.weight;
            ea_reg        <= pair.eps_a;
            eb_reg        <= pair.eps_b;
            sat_reg[0]    <= 1'b0;
            qa_rem_reg[0] <= '0;
            qa_quo_reg[0] <= '0;
            qa_dvd_reg[0] <= {sig_sum, 24'd0};
            for (int i = 1; i <= ljpf_pkg::ST_KDONE; i++)
            begin
                r_reg[i] <= r_reg[i-1];
            end
            for (int i = 1; i <= ljpf_pkg::ST_FMAG; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    dir_reg[i][j] <= dir_reg[i-1][j];
                end
            end
            for (int i = 1; i <= ljpf_pkg::ST_AE; i++)
            begin
                w_reg[i] <= w_reg[i-1];
            end
            for (int i = 1; i <= ljpf_pkg::ST_DPROD; i++)
            begin
                zero_reg[i]  <= zero_reg[i-1];
                close_reg[i] <= close_reg[i-1];
                sat_reg[i]   <= sat_reg[i-1] | sat_in[i];
            end
        end
    end

    // sigma / distance, one quotient bit per stage
    always_comb
    begin
        for (int i = 1; i <= ljpf_pkg::ST_QDONE; i++)
        begin
            qa_try[i] = {qa_rem_reg[i-1], qa_dvd_reg[i-1][ljpf_pkg::Q_W-1]};
            qa_ge[i]  = (qa_try[i] >= {1'b0, r_reg[i-1]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 1; i <= ljpf_pkg::ST_QDONE; i++)
            begin
                qa_rem_reg[i] <= qa_ge[i] ? L'(qa_try[i] - {1'b0, r_reg[i-1]})
                                          : qa_try[i][L-1:0];
                qa_quo_reg[i] <= {qa_quo_reg[i-1][ljpf_pkg::Q_W-2:0], qa_ge[i]};
                qa_dvd_reg[i] <= {qa_dvd_reg[i-1][ljpf_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    // combined depth: square root of eps_a*eps_b, one root bit per stage
    always_comb
    begin
        for (int i = 2; i <= ljpf_pkg::ST_EPS; i++)
        begin
            sq_try[i]   = {sq_rem_reg[i-1], sq_x_reg[i-1][47:46]};
            sq_trial[i] = {2'b00, sq_root_reg[i-1], 2'b01};
            sq_ge[i]    = (sq_try[i] >= sq_trial[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg[1]    <= ea_reg * eb_reg;
            sq_rem_reg[1]  <= '0;
            sq_root_reg[1] <= '0;
            for (int i = 2; i <= ljpf_pkg::ST_EPS; i++)
            begin
                sq_rem_reg[i]  <= sq_ge[i] ? 26'(sq_try[i] - sq_trial[i]) : sq_try[i][25:0];
                sq_root_reg[i] <= {sq_root_reg[i-1][L-2:0], sq_ge[i]};
                sq_x_reg[i]    <= {sq_x_reg[i-1][45:0], 2'b00};
            end
            ae_reg <= alpha_reg * sq_root_reg[ljpf_pkg::ST_EPS];
            c_reg[ljpf_pkg::ST_C] <= ae_reg * w_reg[ljpf_pkg::ST_AE];
            for (int i = ljpf_pkg::ST_C + 1; i <= ljpf_pkg::ST_KDONE; i++)
            begin
                c_reg[i] <= c_reg[i-1];
            end
        end
    end

    // powers of sigma/r
    ljpf_mul u_mul_s2 (
        .clk (clk),
        .en  (en),
        .a   ({15'd0, qa_quo_reg[ljpf_pkg::ST_QDONE]}),
        .b   ({15'd0, qa_quo_reg[ljpf_pkg::ST_QDONE]}),
        .p   (p_s2)
    );

    ljpf_mul u_mul_s4 (
        .clk (clk),
        .en  (en),
        .a   ({2'd0, s2_reg[ljpf_pkg::ST_S2]}),
        .b   ({2'd0, s2_reg[ljpf_pkg::ST_S2]}),
        .p   (p_s4)
    );

    ljpf_mul u_mul_t (
        .clk (clk),
        .en  (en),
        .a   ({2'd0, s4_reg}),
        .b   ({2'd0, s2_reg[ljpf_pkg::ST_S4]}),
        .p   (p_t)
    );

    ljpf_mul u_mul_g (
        .clk (clk),
        .en  (en),
        .a   ({2'd0, t_reg[ljpf_pkg::ST_D]}),
        .b   ({2'd0, d_reg}),
        .p   (p_g)
    );

    ljpf_mul u_mul_gf (
        .clk (clk),
        .en  (en),
        .a   ({2'd0, t_reg[ljpf_pkg::ST_D]}),
        .b   ({1'd0, h_reg}),
        .p   (p_gf)
    );

    ljpf_mul u_mul_e (
        .clk (clk),
        .en  (en),
        .a   (c_reg[ljpf_pkg::ST_G]),
        .b   ({2'd0, g_reg}),
        .p   (p_e)
    );

    ljpf_mul u_mul_f (
        .clk (clk),
        .en  (en),
        .a   (c_reg[ljpf_pkg::ST_KDONE]),
        .b   ({2'd0, k_val}),
        .p   (p_f)
    );

    assign s2_cap = ljpf_pkg::cap_q24(p_s2);
    assign s4_cap = ljpf_pkg::cap_q24(p_s4);
    assign t_cap  = ljpf_pkg::cap_q24(p_t);
    assign g_cap  = ljpf_pkg::cap_q24(p_g);
    assign gf_cap = ljpf_pkg::cap_q24(p_gf);
    assign e_cap  = ljpf_pkg::cap_q54(p_e);
    assign f_cap  = ljpf_pkg::cap_q54(p_f);

    assign attr_q = {attract_reg, 24'd0};
    assign attr62 = {37'd0, attr_q};
    assign attr63 = {38'd0, attr_q};
    assign two_t  = {t_reg[ljpf_pkg::ST_T], 1'b0};

    assign gf_lim_sat = (gf_reg > ljpf_pkg::GF_LIM);
    assign k_ovf      = ({8'd0, gf6_reg} >= {r_reg[ljpf_pkg::ST_GF6], 46'd0});
    assign k_val      = ksat_reg[ljpf_pkg::ST_KDONE] ? ljpf_pkg::ICAP
                                                     : kb_quo_reg[ljpf_pkg::ST_KDONE];

    always_comb
    begin
        sat_in                    = '0;
        sat_in[ljpf_pkg::ST_S2]   = s2_cap[ljpf_pkg::I_W];
        sat_in[ljpf_pkg::ST_S4]   = s4_cap[ljpf_pkg::I_W];
        sat_in[ljpf_pkg::ST_T]    = t_cap[ljpf_pkg::I_W];
        sat_in[ljpf_pkg::ST_G]    = g_cap[ljpf_pkg::I_W] | gf_cap[ljpf_pkg::I_W];
        sat_in[ljpf_pkg::ST_GF6]  = gf_lim_sat;
        sat_in[ljpf_pkg::ST_KINIT] = k_ovf;
        sat_in[ljpf_pkg::ST_EMAG] = e_cap[ljpf_pkg::O_W];
        sat_in[ljpf_pkg::ST_FMAG] = f_cap[ljpf_pkg::O_W];
    end

    // energy and force terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg[ljpf_pkg::ST_S2] <= s2_cap[ljpf_pkg::I_W-1:0];
            for (int i = ljpf_pkg::ST_S2 + 1; i <= ljpf_pkg::ST_S4; i++)
            begin
                s2_reg[i] <= s2_reg[i-1];
            end
            s4_reg <= s4_cap[ljpf_pkg::I_W-1:0];
            t_reg[ljpf_pkg::ST_T] <= t_cap[ljpf_pkg::I_W-1:0];
            t_reg[ljpf_pkg::ST_D] <= t_reg[ljpf_pkg::ST_T];

            if (t_reg[ljpf_pkg::ST_T] >= attr62)
            begin
                d_reg <= t_reg[ljpf_pkg::ST_T] - attr62;
                eneg_reg[ljpf_pkg::ST_D] <= 1'b0;
            end
            else
            begin
                d_reg <= attr62 - t_reg[ljpf_pkg::ST_T];
                eneg_reg[ljpf_pkg::ST_D] <= 1'b1;
            end
            if (two_t >= attr63)
            begin
                h_reg <= two_t - attr63;
                fneg_reg[ljpf_pkg::ST_D] <= 1'b0;
            end
            else
            begin
                h_reg <= attr63 - two_t;
                fneg_reg[ljpf_pkg::ST_D] <= 1'b1;
            end
            for (int i = ljpf_pkg::ST_D + 1; i < ljpf_pkg::ST_EMAG; i++)
            begin
                eneg_reg[i] <= eneg_reg[i-1];
            end
            for (int i = ljpf_pkg::ST_D + 1; i <= ljpf_pkg::ST_DPROD; i++)
            begin
                fneg_reg[i] <= fneg_reg[i-1];
            end

            g_reg  <= g_cap[ljpf_pkg::I_W-1:0];
            gf_reg <= gf_cap[ljpf_pkg::I_W-1:0];
            gf6_reg <= gf_lim_sat ? ljpf_pkg::ICAP
                                  : ljpf_pkg::I_W'({gf_reg, 2'b00} + {1'b0, gf_reg, 1'b0});

            ksat_reg[ljpf_pkg::ST_KINIT]   <= k_ovf;
            kb_rem_reg[ljpf_pkg::ST_KINIT] <= {8'd0, gf6_reg[61:46]};
            kb_dvd_reg[ljpf_pkg::ST_KINIT] <= {gf6_reg[45:0], 16'd0};
            kb_quo_reg[ljpf_pkg::ST_KINIT] <= '0;
            for (int i = ljpf_pkg::ST_KINIT + 1; i <= ljpf_pkg::ST_KDONE; i++)
            begin
                ksat_reg[i]   <= ksat_reg[i-1];
                kb_rem_reg[i] <= kb_ge[i] ? L'(kb_try[i] - {1'b0, r_reg[i-1]})
                                          : kb_try[i][L-1:0];
                kb_quo_reg[i] <= {kb_quo_reg[i-1][ljpf_pkg::I_W-2:0], kb_ge[i]};
                kb_dvd_reg[i] <= {kb_dvd_reg[i-1][ljpf_pkg::I_W-2:0], 1'b0};
            end

            energy_reg[ljpf_pkg::ST_EMAG] <= eneg_reg[ljpf_pkg::ST_EMAG-1]
                ? ljpf_pkg::RES_W'(48'd0 - {1'b0, e_cap[ljpf_pkg::O_W-1:0]})
                : {1'b0, e_cap[ljpf_pkg::O_W-1:0]};
            for (int i = ljpf_pkg::ST_EMAG + 1; i <= ljpf_pkg::ST_DPROD; i++)
            begin
                energy_reg[i] <= energy_reg[i-1];
            end

            fmag_reg <= f_cap[ljpf_pkg::O_W-1:0];
            for (int j = 0; j < 3; j++)
            begin
                dprod_reg[j] <= dmag[j] * fmag_reg;
                dneg_reg[j]  <= dir_reg[ljpf_pkg::ST_FMAG][j][ljpf_pkg::DIR_W-1];
            end
        end
    end

    // force over distance, one quotient bit per stage
    always_comb
    begin
        for (int i = ljpf_pkg::ST_KINIT + 1; i <= ljpf_pkg::ST_KDONE; i++)
        begin
            kb_try[i] = {kb_rem_reg[i-1], kb_dvd_reg[i-1][ljpf_pkg::I_W-1]};
            kb_ge[i]  = (kb_try[i] >= {1'b0, r_reg[i-1]});
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            dmag[j] = dir_reg[ljpf_pkg::ST_FMAG][j][ljpf_pkg::DIR_W-1]
                    ? ljpf_pkg::DIR_W'(~dir_reg[ljpf_pkg::ST_FMAG][j] + 16'd1)
                    : dir_reg[ljpf_pkg::ST_FMAG][j];
        end
    end

    // final scaling, sign and zero distance handling
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            fm[j]    = dprod_reg[j][62:14];
            f_sat[j] = (fm[j][48:47] != 2'b00);
            f_mag[j] = f_sat[j] ? ljpf_pkg::OCAP : fm[j][46:0];
            f_val[j] = (dneg_reg[j] ^ fneg_reg[ljpf_pkg::ST_DPROD])
                     ? ljpf_pkg::RES_W'(48'd0 - {1'b0, f_mag[j]})
                     : {1'b0, f_mag[j]};
        end
        res_next.too_close = close_reg[ljpf_pkg::ST_DPROD];
        if (zero_reg[ljpf_pkg::ST_DPROD])
        begin
            res_next.force_x     = '0;
            res_next.force_y     = '0;
            res_next.force_z     = '0;
            res_next.energy_term = '0;
            res_next.overflow    = 1'b1;
        end
        else
        begin
            res_next.force_x     = f_val[0];
            res_next.force_y     = f_val[1];
            res_next.force_z     = f_val[2];
            res_next.energy_term = energy_reg[ljpf_pkg::ST_DPROD];
            res_next.overflow    = sat_reg[ljpf_pkg::ST_DPROD] | (|f_sat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    // output register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            if (vld_reg[ljpf_pkg::ST_LAST])
            begin
                if (!out_vld_reg || take)
                begin
                    out_vld_reg <= 1'b1;
                end
                else
                begin
                    skid_vld_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                out_vld_reg <= 1'b0;
            end
        end
        else if (take)
        begin
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (vld_reg[ljpf_pkg::ST_LAST] && (!out_vld_reg || take))
            begin
                out_reg <= res_reg;
            end
            if (vld_reg[ljpf_pkg::ST_LAST] && out_vld_reg && !take)
            begin
                skid_reg <= res_reg;
            end
        end
        else if (take)
        begin
            out_reg <= skid_reg;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.force_x     = out_reg.force_x;
    assign result.force_y     = out_reg.force_y;
    assign result.force_z     = out_reg.force_z;
    assign result.energy_term = out_reg.energy_term;
    assign result.too_close   = out_reg.too_close;
    assign result.overflow    = out_reg.overflow;

    `ASSERT_IMPL(a_skid_needs_out, clk, rst_n, skid_vld_reg, out_vld_reg)
    `ASSERT_NEXT(a_result_held, clk, rst_n, out_vld_reg && !result.ready, out_vld_reg)
    `ASSERT_IMPL(a_skid_fill, clk, rst_n, $rose(skid_vld_reg), $past(out_vld_reg && !result.ready))

endmodule
